// ----- rtl/pscb_pkg.sv -----
// shared types and constants for the periodic stencil csr row builder
// no dependencies; used by pscb_ctrl, pscb_dpath and the top level
`default_nettype none

package pscb_pkg;

    localparam int IDX_W          = 24;
    localparam int VAL_W          = 32;
    localparam int PTR_W          = 27;
    localparam int EXT_W          = 9;
    localparam int CFG_IDX_W      = 2;
    localparam int STENCIL_POINTS = 7;
    localparam int STEP_W         = 3;

    localparam logic [EXT_W-1:0]     EXTENT_RESET = 9'd16;
    localparam logic [STEP_W-1:0]    LAST_STEP    = STEP_W'(STENCIL_POINTS - 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_I = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_J = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_K = 2'd2;

    // stencil positions before sorting
    localparam int POS_BOTTOM = 0;
    localparam int POS_SOUTH  = 1;
    localparam int POS_WEST   = 2;
    localparam int POS_DIAG   = 3;
    localparam int POS_EAST   = 4;
    localparam int POS_NORTH  = 5;
    localparam int POS_TOP    = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SPAN,
        ST_COLS,
        ST_SORT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              capture;
        logic              mul;
        logic              span;
        logic              cols;
        logic              sort;
        logic              emit;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/pscb_ctrl.sv -----
// sequencing state machine for the periodic stencil csr row builder
// depends on pscb_pkg; drives pscb_dpath through cmd_t, reads status_t
`default_nettype none

module pscb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    output pscb_pkg::cmd_t         cmd,
    input  wire pscb_pkg::status_t status
);

    pscb_pkg::state_t                  state_reg, state_next;
    logic [pscb_pkg::STEP_W-1:0]       step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pscb_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            pscb_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = pscb_pkg::ST_MUL;
                    step_next  = '0;
                end
            end
            pscb_pkg::ST_MUL:
                state_next = pscb_pkg::ST_SPAN;
            pscb_pkg::ST_SPAN:
                state_next = pscb_pkg::ST_COLS;
            pscb_pkg::ST_COLS:
            begin
                state_next = pscb_pkg::ST_SORT;
                step_next  = '0;
            end
            pscb_pkg::ST_SORT:
            begin
                if (step_reg == pscb_pkg::LAST_STEP)
                begin
                    state_next = pscb_pkg::ST_EMIT;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + pscb_pkg::STEP_W'(1);
                end
            end
            pscb_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (step_reg == pscb_pkg::LAST_STEP)
                    begin
                        state_next = pscb_pkg::ST_IDLE;
                        step_next  = '0;
                    end
                    else
                    begin
                        step_next = step_reg + pscb_pkg::STEP_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = pscb_pkg::ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        item_stall  = (state_reg != pscb_pkg::ST_IDLE);
        cmd.capture = (state_reg == pscb_pkg::ST_IDLE) && item_valid;
        cmd.mul     = (state_reg == pscb_pkg::ST_MUL);
        cmd.span    = (state_reg == pscb_pkg::ST_SPAN);
        cmd.cols    = (state_reg == pscb_pkg::ST_COLS);
        cmd.sort    = (state_reg == pscb_pkg::ST_SORT);
        cmd.emit    = (state_reg == pscb_pkg::ST_EMIT);
        cmd.step    = step_reg;
    end

    a_capture_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == pscb_pkg::ST_MUL))
        else $error("accepted word did not start the arithmetic phase");

    a_sort_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sort && step_reg == pscb_pkg::LAST_STEP)
        |=> (state_reg == pscb_pkg::ST_EMIT && step_reg == '0))
        else $error("emit did not follow the final sort pass");

    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.out_free && step_reg == pscb_pkg::LAST_STEP)
        |=> (state_reg == pscb_pkg::ST_IDLE))
        else $error("controller did not return to idle after the seventh entry");

endmodule

`default_nettype wire

// ----- rtl/pscb_dpath.sv -----
// datapath: extent registers, cell counters, diagonal, columns, sorter, output register
// depends on pscb_pkg; sequenced by pscb_ctrl through cmd_t
`default_nettype none

module pscb_dpath #(
    parameter int MAX_EXTENT = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pscb_pkg::cmd_t                      cmd,
    output pscb_pkg::status_t                        status,
    input  wire logic                                cfg_valid,
    input  wire logic [pscb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pscb_pkg::EXT_W-1:0]          cfg_data,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   alpha,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_east,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_west,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_north,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_south,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_top,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_bottom,
    output logic                                     entry_valid,
    input  wire logic                                entry_stall,
    output logic [pscb_pkg::IDX_W-1:0]               row_index,
    output logic [pscb_pkg::IDX_W-1:0]               column_index,
    output logic signed [pscb_pkg::VAL_W-1:0]        entry_value,
    output logic                                     last_in_row,
    output logic [pscb_pkg::PTR_W-1:0]               row_end_pointer,
    output logic                                     diag_saturated,
    output logic                                     grid_done
);

    localparam int CW = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
    localparam int EW = $clog2(MAX_EXTENT + 1);
    localparam int IW = pscb_pkg::IDX_W;
    localparam int VW = pscb_pkg::VAL_W;
    localparam int NP = pscb_pkg::STENCIL_POINTS;

    // configuration and walk state
    logic [pscb_pkg::EXT_W-1:0] ext_i_reg, ext_j_reg, ext_k_reg;
    logic [CW-1:0]              cell_i_reg, cell_i_next;
    logic [CW-1:0]              cell_j_reg, cell_j_next;
    logic [CW-1:0]              cell_k_reg, cell_k_next;
    logic [IW-1:0]              row_counter_reg, row_counter_next;

    logic [EW-1:0] ni, nj, nk;
    logic          i_last, j_last, k_last, grid_last;
    logic          cfg_hit;

    // per-item working registers
    logic signed [VW-1:0] alpha_reg, east_reg, west_reg, north_reg;
    logic signed [VW-1:0] south_reg, top_reg, bottom_reg;
    logic signed [VW+1:0] s1_reg, s2_reg;
    logic signed [VW-1:0] diag_reg;
    logic                 diag_sat_reg;
    logic [IW-1:0]        row_reg, plane_reg, span_j_reg, span_k_reg;
    logic [pscb_pkg::PTR_W-1:0] rowend_reg;
    logic                 lo_i_reg, lo_j_reg, lo_k_reg;
    logic                 hi_i_reg, hi_j_reg, hi_k_reg;
    logic                 done_reg;

    logic [2*EW-1:0]      plane_prod, span_j_prod;
    logic [EW+IW-1:0]     span_k_prod;
    logic signed [VW+3:0] diag_full;
    logic [IW:0]          row_plus;
    logic [IW+3:0]        rowend_full;

    // sorter storage
    logic [IW-1:0]        col_reg [NP];
    logic [IW-1:0]        col_next [NP];
    logic signed [VW-1:0] val_reg [NP];
    logic signed [VW-1:0] val_next [NP];
    logic [NP-1:0]        sat_reg, sat_next;

    logic [IW-1:0] ni_w, nj_w, base;

    // output register
    logic out_valid_reg, out_valid_next;

    function automatic logic [EW-1:0] eff_extent(input logic [pscb_pkg::EXT_W-1:0] v);
        logic [EW-1:0] r;
        if (v == '0)
            r = EW'(1);
        else if (32'(v) > 32'(MAX_EXTENT))
            r = EW'(MAX_EXTENT);
        else
            r = EW'(v);
        return r;
    endfunction

    assign ni = eff_extent(ext_i_reg);
    assign nj = eff_extent(ext_j_reg);
    assign nk = eff_extent(ext_k_reg);

    assign i_last    = (EW'(cell_i_reg) + EW'(1)) >= ni;
    assign j_last    = (EW'(cell_j_reg) + EW'(1)) >= nj;
    assign k_last    = (EW'(cell_k_reg) + EW'(1)) >= nk;
    assign grid_last = i_last && j_last && k_last;

    assign cfg_hit = cfg_valid && ((cfg_index == pscb_pkg::REG_EXTENT_I)
                                || (cfg_index == pscb_pkg::REG_EXTENT_J)
                                || (cfg_index == pscb_pkg::REG_EXTENT_K));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_i_reg <= pscb_pkg::EXTENT_RESET;
            ext_j_reg <= pscb_pkg::EXTENT_RESET;
            ext_k_reg <= pscb_pkg::EXTENT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pscb_pkg::REG_EXTENT_I: ext_i_reg <= cfg_data;
                pscb_pkg::REG_EXTENT_J: ext_j_reg <= cfg_data;
                pscb_pkg::REG_EXTENT_K: ext_k_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // walk counters, advanced as a cell is taken in, cleared by an extent write or after the last cell
    always_comb
    begin
        cell_i_next      = cell_i_reg;
        cell_j_next      = cell_j_reg;
        cell_k_next      = cell_k_reg;
        row_counter_next = row_counter_reg;
        if (cfg_hit || (cmd.capture && grid_last))
        begin
            cell_i_next      = '0;
            cell_j_next      = '0;
            cell_k_next      = '0;
            row_counter_next = '0;
        end
        else if (cmd.capture)
        begin
            row_counter_next = row_counter_reg + IW'(1);
            if (!i_last)
                cell_i_next = cell_i_reg + CW'(1);
            else
            begin
                cell_i_next = '0;
                if (!j_last)
                    cell_j_next = cell_j_reg + CW'(1);
                else
                begin
                    cell_j_next = '0;
                    cell_k_next = cell_k_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_i_reg      <= '0;
            cell_j_reg      <= '0;
            cell_k_reg      <= '0;
            row_counter_reg <= '0;
        end
        else
        begin
            cell_i_reg      <= cell_i_next;
            cell_j_reg      <= cell_j_next;
            cell_k_reg      <= cell_k_next;
            row_counter_reg <= row_counter_next;
        end
    end

    assign plane_prod  = (2*EW)'(ni) * (2*EW)'(nj);
    assign span_j_prod = (2*EW)'(nj - EW'(1)) * (2*EW)'(ni);
    assign span_k_prod = (EW+IW)'(nk - EW'(1)) * (EW+IW)'(plane_reg);
    assign diag_full   = (VW+4)'(alpha_reg) - ((VW+4)'(s1_reg) + (VW+4)'(s2_reg));
    assign row_plus    = {1'b0, row_reg} + (IW+1)'(1);
    assign rowend_full = {row_plus, 3'b000} - {3'b000, row_plus};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            alpha_reg  <= alpha;
            east_reg   <= coef_east;
            west_reg   <= coef_west;
            north_reg  <= coef_north;
            south_reg  <= coef_south;
            top_reg    <= coef_top;
            bottom_reg <= coef_bottom;
            row_reg    <= row_counter_reg;
            lo_i_reg   <= (cell_i_reg == '0);
            lo_j_reg   <= (cell_j_reg == '0);
            lo_k_reg   <= (cell_k_reg == '0);
            hi_i_reg   <= i_last;
            hi_j_reg   <= j_last;
            hi_k_reg   <= k_last;
            done_reg   <= grid_last;
        end
        if (cmd.mul)
        begin
            plane_reg  <= IW'(plane_prod);
            span_j_reg <= IW'(span_j_prod);
            s1_reg     <= (VW+2)'(east_reg) + (VW+2)'(west_reg) + (VW+2)'(north_reg);
            s2_reg     <= (VW+2)'(south_reg) + (VW+2)'(top_reg) + (VW+2)'(bottom_reg);
            rowend_reg <= pscb_pkg::PTR_W'(rowend_full);
        end
        if (cmd.span)
        begin
            span_k_reg <= IW'(span_k_prod);
            // clip when the top five bits disagree
            if ((&diag_full[VW+3:VW-1]) || !(|diag_full[VW+3:VW-1]))
            begin
                diag_reg     <= diag_full[VW-1:0];
                diag_sat_reg <= 1'b0;
            end
            else
            begin
                diag_reg     <= diag_full[VW+3] ? {1'b1, {(VW-1){1'b0}}}
                                                : {1'b0, {(VW-1){1'b1}}};
                diag_sat_reg <= 1'b1;
            end
        end
    end

    assign ni_w = IW'(ni);
    assign nj_w = IW'(nj);
    assign base = row_reg;

    // neighbour columns with periodic wrap, then odd-even transposition passes
    always_comb
    begin
        col_next = col_reg;
        val_next = val_reg;
        sat_next = sat_reg;
        if (cmd.cols)
        begin
            col_next[pscb_pkg::POS_BOTTOM] = lo_k_reg ? base + span_k_reg : base - plane_reg;
            col_next[pscb_pkg::POS_SOUTH]  = lo_j_reg ? base + span_j_reg : base - ni_w;
            col_next[pscb_pkg::POS_WEST]   = lo_i_reg ? base + (ni_w - IW'(1)) : base - IW'(1);
            col_next[pscb_pkg::POS_DIAG]   = base;
            col_next[pscb_pkg::POS_EAST]   = hi_i_reg ? base - (ni_w - IW'(1)) : base + IW'(1);
            col_next[pscb_pkg::POS_NORTH]  = hi_j_reg ? base - span_j_reg : base + ni_w;
            col_next[pscb_pkg::POS_TOP]    = hi_k_reg ? base - span_k_reg : base + plane_reg;
            val_next[pscb_pkg::POS_BOTTOM] = bottom_reg;
            val_next[pscb_pkg::POS_SOUTH]  = south_reg;
            val_next[pscb_pkg::POS_WEST]   = west_reg;
            val_next[pscb_pkg::POS_DIAG]   = diag_reg;
            val_next[pscb_pkg::POS_EAST]   = east_reg;
            val_next[pscb_pkg::POS_NORTH]  = north_reg;
            val_next[pscb_pkg::POS_TOP]    = top_reg;
            sat_next                       = '0;
            sat_next[pscb_pkg::POS_DIAG]   = diag_sat_reg;
        end
        else if (cmd.sort)
        begin
            // strict compare keeps tied entries in stencil order
            for (int q = 0; q < (NP - 1) / 2; q++)
            begin
                if (!cmd.step[0])
                begin
                    if (col_reg[2*q] > col_reg[2*q+1])
                    begin
                        col_next[2*q]   = col_reg[2*q+1];
                        col_next[2*q+1] = col_reg[2*q];
                        val_next[2*q]   = val_reg[2*q+1];
                        val_next[2*q+1] = val_reg[2*q];
                        sat_next[2*q]   = sat_reg[2*q+1];
                        sat_next[2*q+1] = sat_reg[2*q];
                    end
                end
                else
                begin
                    if (col_reg[2*q+1] > col_reg[2*q+2])
                    begin
                        col_next[2*q+1] = col_reg[2*q+2];
                        col_next[2*q+2] = col_reg[2*q+1];
                        val_next[2*q+1] = val_reg[2*q+2];
                        val_next[2*q+2] = val_reg[2*q+1];
                        sat_next[2*q+1] = sat_reg[2*q+2];
                        sat_next[2*q+2] = sat_reg[2*q+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        val_reg <= val_next;
        sat_reg <= sat_next;
    end

    // output register, refilled as soon as the held word is taken
    assign status.out_free = !out_valid_reg || !entry_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit && status.out_free)
            out_valid_next = 1'b1;
        else if (!entry_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && status.out_free)
        begin
            row_index       <= row_reg;
            column_index    <= col_reg[cmd.step];
            entry_value     <= val_reg[cmd.step];
            last_in_row     <= (cmd.step == pscb_pkg::LAST_STEP);
            row_end_pointer <= (cmd.step == pscb_pkg::LAST_STEP) ? rowend_reg : '0;
            diag_saturated  <= sat_reg[cmd.step];
            grid_done       <= (cmd.step == pscb_pkg::LAST_STEP) && done_reg;
        end
    end

    assign entry_valid = out_valid_reg;

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (col_reg[0] <= col_reg[1]) && (col_reg[1] <= col_reg[2])
                  && (col_reg[2] <= col_reg[3]) && (col_reg[3] <= col_reg[4])
                  && (col_reg[4] <= col_reg[5]) && (col_reg[5] <= col_reg[6]))
        else $error("entries not in column order at emit");

    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_valid && diag_saturated)
        |-> (entry_value == 32'sh7fffffff || entry_value == 32'sh80000000))
        else $error("saturated diagonal word is not a clip value");

endmodule

`default_nettype wire

// ----- rtl/periodic_stencil_csr_row_builder.sv -----
// top level of the periodic stencil csr row builder
// depends on pscb_pkg, pscb_ctrl and pscb_dpath
`default_nettype none

// Takes one grid cell per accepted word (i fastest, then j, then k) and returns seven
// CSR entries for its row, sorted by column with periodic wrap on every axis; tied
// columns keep the order bottom, south, west, diag, east, north, top. The diagonal is
// alpha minus the six faces, clipped to 32 bits. A cell is taken in while idle; then
// the MUL and SPAN states form the multiplies and diagonal sum, COLS forms the columns,
// seven odd-even sort passes run through the shared compare-exchange row, and EMIT hands
// the entries out one a cycle via the output register unless the result side stalls.
// Any write to an extent register restarts the walk at cell zero; extents of 0 act as 1
// and extents above MAX_EXTENT act as MAX_EXTENT. The configuration port is always ready.
module periodic_stencil_csr_row_builder #(
    parameter int MAX_EXTENT = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pscb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pscb_pkg::EXT_W-1:0]          cfg_data,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   alpha,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_east,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_west,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_north,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_south,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_top,
    input  wire logic signed [pscb_pkg::VAL_W-1:0]   coef_bottom,
    output logic                                     entry_valid,
    input  wire logic                                entry_stall,
    output logic [pscb_pkg::IDX_W-1:0]               row_index,
    output logic [pscb_pkg::IDX_W-1:0]               column_index,
    output logic signed [pscb_pkg::VAL_W-1:0]        entry_value,
    output logic                                     last_in_row,
    output logic [pscb_pkg::PTR_W-1:0]               row_end_pointer,
    output logic                                     diag_saturated,
    output logic                                     grid_done
);

    pscb_pkg::cmd_t    cmd;
    pscb_pkg::status_t status;

    assign cfg_ready = 1'b1;

    pscb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .status     (status)
    );

    pscb_dpath #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .alpha           (alpha),
        .coef_east       (coef_east),
        .coef_west       (coef_west),
        .coef_north      (coef_north),
        .coef_south      (coef_south),
        .coef_top        (coef_top),
        .coef_bottom     (coef_bottom),
        .entry_valid     (entry_valid),
        .entry_stall     (entry_stall),
        .row_index       (row_index),
        .column_index    (column_index),
        .entry_value     (entry_value),
        .last_in_row     (last_in_row),
        .row_end_pointer (row_end_pointer),
        .diag_saturated  (diag_saturated),
        .grid_done       (grid_done)
    );

endmodule

`default_nettype wire

// ----- bench/periodic_stencil_csr_row_builder_test.sv -----
// self-checking bench for periodic_stencil_csr_row_builder: directed cells, then random grids
// depends on pscb_pkg and the periodic_stencil_csr_row_builder top level
module periodic_stencil_csr_row_builder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint GRID_MAX     = 256;
    localparam int     LONG_HOLD    = 300;
    localparam int     RANDOM_CELLS = 480;
    localparam int     MAX_PRINTED  = 100;

    localparam logic [pscb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [pscb_pkg::VAL_W-1:0]     POS_FULL   = 32'h7FFF_FFFF;
    localparam logic [pscb_pkg::VAL_W-1:0]     NEG_FULL   = 32'h8000_0000;
    localparam longint                         DIAG_MAX   = 64'sd2147483647;
    localparam longint                         DIAG_MIN   = -64'sd2147483648;

    typedef struct {
        logic signed [pscb_pkg::VAL_W-1:0] alpha;
        logic signed [pscb_pkg::VAL_W-1:0] east;
        logic signed [pscb_pkg::VAL_W-1:0] west;
        logic signed [pscb_pkg::VAL_W-1:0] north;
        logic signed [pscb_pkg::VAL_W-1:0] south;
        logic signed [pscb_pkg::VAL_W-1:0] top;
        logic signed [pscb_pkg::VAL_W-1:0] bottom;
    } cell_t;

    typedef struct {
        logic [pscb_pkg::IDX_W-1:0]        row;
        logic [pscb_pkg::IDX_W-1:0]        col;
        logic signed [pscb_pkg::VAL_W-1:0] value;
        logic                              last;
        logic [pscb_pkg::PTR_W-1:0]        end_ptr;
        logic                              clipped;
        logic                              done;
    } entry_t;

    typedef struct {
        logic [pscb_pkg::CFG_IDX_W-1:0] index;
        logic [pscb_pkg::EXT_W-1:0]     data;
    } reg_write_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [pscb_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [pscb_pkg::EXT_W-1:0]        cfg_data  = '0;
    logic                              item_valid = 1'b0;
    logic                              item_stall;
    logic signed [pscb_pkg::VAL_W-1:0] alpha       = '0;
    logic signed [pscb_pkg::VAL_W-1:0] coef_east   = '0;
    logic signed [pscb_pkg::VAL_W-1:0] coef_west   = '0;
    logic signed [pscb_pkg::VAL_W-1:0] coef_north  = '0;
    logic signed [pscb_pkg::VAL_W-1:0] coef_south  = '0;
    logic signed [pscb_pkg::VAL_W-1:0] coef_top    = '0;
    logic signed [pscb_pkg::VAL_W-1:0] coef_bottom = '0;
    logic                              entry_valid;
    logic                              entry_stall = 1'b0;
    logic [pscb_pkg::IDX_W-1:0]        row_index;
    logic [pscb_pkg::IDX_W-1:0]        column_index;
    logic signed [pscb_pkg::VAL_W-1:0] entry_value;
    logic                              last_in_row;
    logic [pscb_pkg::PTR_W-1:0]        row_end_pointer;
    logic                              diag_saturated;
    logic                              grid_done;

    periodic_stencil_csr_row_builder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .alpha           (alpha),
        .coef_east       (coef_east),
        .coef_west       (coef_west),
        .coef_north      (coef_north),
        .coef_south      (coef_south),
        .coef_top        (coef_top),
        .coef_bottom     (coef_bottom),
        .entry_valid     (entry_valid),
        .entry_stall     (entry_stall),
        .row_index       (row_index),
        .column_index    (column_index),
        .entry_value     (entry_value),
        .last_in_row     (last_in_row),
        .row_end_pointer (row_end_pointer),
        .diag_saturated  (diag_saturated),
        .grid_done       (grid_done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // queues shared by the stimulus, the drivers and the monitor
    cell_t      pending_cells[$];
    reg_write_t reg_writes[$];
    entry_t     expected_entries[$];

    // predictor state: extent registers and the cell walk
    logic [pscb_pkg::EXT_W-1:0] ext_i = pscb_pkg::EXTENT_RESET;
    logic [pscb_pkg::EXT_W-1:0] ext_j = pscb_pkg::EXTENT_RESET;
    logic [pscb_pkg::EXT_W-1:0] ext_k = pscb_pkg::EXTENT_RESET;
    int                         at_i = 0;
    int                         at_j = 0;
    int                         at_k = 0;
    logic [pscb_pkg::IDX_W-1:0] at_row = '0;

    int   idle_mode     = 0;
    bit   hold_items    = 1'b0;
    int   hold_requests = 0;
    int   mismatches    = 0;
    int   entries_seen  = 0;

    function automatic longint effective_extent(input logic [pscb_pkg::EXT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > GRID_MAX)
            return GRID_MAX;
        return longint'(v);
    endfunction

    task automatic apply_register_write(input logic [pscb_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [pscb_pkg::EXT_W-1:0] data);
        case (idx)
            pscb_pkg::REG_EXTENT_I: ext_i = data;
            pscb_pkg::REG_EXTENT_J: ext_j = data;
            pscb_pkg::REG_EXTENT_K: ext_k = data;
            default: return;
        endcase
        at_i   = 0;
        at_j   = 0;
        at_k   = 0;
        at_row = '0;
    endtask

    // seven sorted entries per cell, diagonal clipped to 32 bits
    task automatic predict_cell(input cell_t c);
        longint                            ni, nj, nk, i, j, k, diag;
        longint                            col [pscb_pkg::STENCIL_POINTS];
        logic signed [pscb_pkg::VAL_W-1:0] val [pscb_pkg::STENCIL_POINTS];
        int                                ord [pscb_pkg::STENCIL_POINTS];
        int                                p, q, cur;
        logic                              clipped, finished;
        entry_t                            e;

        ni = effective_extent(ext_i);
        nj = effective_extent(ext_j);
        nk = effective_extent(ext_k);
        i  = at_i;
        j  = at_j;
        k  = at_k;

        diag = longint'(c.alpha) - (longint'(c.east) + longint'(c.west) + longint'(c.north)
               + longint'(c.south) + longint'(c.top) + longint'(c.bottom));
        clipped = 1'b0;
        if (diag > DIAG_MAX)
        begin
            diag    = DIAG_MAX;
            clipped = 1'b1;
        end
        else if (diag < DIAG_MIN)
        begin
            diag    = DIAG_MIN;
            clipped = 1'b1;
        end

        col[pscb_pkg::POS_BOTTOM] = ((((k + nk - 1) % nk) * nj) + j) * ni + i;
        col[pscb_pkg::POS_SOUTH]  = ((k * nj) + ((j + nj - 1) % nj)) * ni + i;
        col[pscb_pkg::POS_WEST]   = ((k * nj) + j) * ni + ((i + ni - 1) % ni);
        col[pscb_pkg::POS_DIAG]   = ((k * nj) + j) * ni + i;
        col[pscb_pkg::POS_EAST]   = ((k * nj) + j) * ni + ((i + 1) % ni);
        col[pscb_pkg::POS_NORTH]  = ((k * nj) + ((j + 1) % nj)) * ni + i;
        col[pscb_pkg::POS_TOP]    = ((((k + 1) % nk) * nj) + j) * ni + i;
        val[pscb_pkg::POS_BOTTOM] = c.bottom;
        val[pscb_pkg::POS_SOUTH]  = c.south;
        val[pscb_pkg::POS_WEST]   = c.west;
        val[pscb_pkg::POS_DIAG]   = diag[pscb_pkg::VAL_W-1:0];
        val[pscb_pkg::POS_EAST]   = c.east;
        val[pscb_pkg::POS_NORTH]  = c.north;
        val[pscb_pkg::POS_TOP]    = c.top;

        // insertion sort keeps stencil order among equal columns
        for (p = 0; p < pscb_pkg::STENCIL_POINTS; p++)
        begin
            cur = p;
            q   = p;
            while (q > 0 && col[ord[q-1]] > col[cur])
            begin
                ord[q] = ord[q-1];
                q--;
            end
            ord[q] = cur;
        end

        finished = (i + 1 >= ni) && (j + 1 >= nj) && (k + 1 >= nk);
        for (p = 0; p < pscb_pkg::STENCIL_POINTS; p++)
        begin
            e.row     = at_row;
            e.col     = col[ord[p]][pscb_pkg::IDX_W-1:0];
            e.value   = val[ord[p]];
            e.last    = (p == pscb_pkg::STENCIL_POINTS - 1);
            e.end_ptr = e.last ? pscb_pkg::PTR_W'((longint'(at_row) + 1)
                                                  * pscb_pkg::STENCIL_POINTS) : '0;
            e.clipped = (ord[p] == pscb_pkg::POS_DIAG) && clipped;
            e.done    = e.last && finished;
            expected_entries.insert(expected_entries.size(), e);
        end

        if (finished)
        begin
            at_i   = 0;
            at_j   = 0;
            at_k   = 0;
            at_row = '0;
        end
        else
        begin
            at_row = at_row + 1'b1;
            if (i + 1 < ni)
                at_i = int'(i) + 1;
            else
            begin
                at_i = 0;
                if (j + 1 < nj)
                    at_j = int'(j) + 1;
                else
                begin
                    at_j = 0;
                    at_k = int'(k) + 1;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_PRINTED)
            $display("entry %0d: %s is %0h, expected %0h", entries_seen, what, got, want);
        mismatches++;
    endtask

    // configuration driver
    reg_write_t next_write;

    always @(posedge clk)
    begin
        if (!rst_n)
            cfg_valid <= 1'b0;
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register_write(cfg_index, cfg_data);
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_writes.size() != 0)
                begin
                    next_write = reg_writes.pop_front();
                    cfg_index <= next_write.index;
                    cfg_data  <= next_write.data;
                    cfg_valid <= 1'b1;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // cell driver: bursts and gaps, a stalled word is held as it is
    cell_t offered;
    int    gap_left   = 0;
    int    burst_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
                predict_cell(offered);
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (hold_items || pending_cells.size() == 0)
                    item_valid <= 1'b0;
                else
                begin
                    offered = pending_cells.pop_front();
                    alpha       <= offered.alpha;
                    coef_east   <= offered.east;
                    coef_west   <= offered.west;
                    coef_north  <= offered.north;
                    coef_south  <= offered.south;
                    coef_top    <= offered.top;
                    coef_bottom <= offered.bottom;
                    item_valid  <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else if (idle_mode == 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
                    end
                    else if (idle_mode == 2)
                    begin
                        burst_left = $urandom_range(0, 4);
                        gap_left   = $urandom_range(0, 20);
                    end
                end
            end
        end
    end

    // receiver stall pattern, plus the long hold-off counted here
    logic [15:0] stall_pattern = '0;
    int          pattern_age   = 0;
    int          hold_left     = 0;
    int          holds_served  = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            entry_stall <= 1'b0;
        else
        begin
            if (holds_served != hold_requests)
            begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                entry_stall <= 1'b1;
            end
            else
            begin
                if (pattern_age == 0)
                begin
                    if (idle_mode == 1)
                        stall_pattern = 16'($urandom & $urandom);
                    else
                        stall_pattern = 16'($urandom | $urandom);
                    pattern_age = 16;
                end
                pattern_age--;
                entry_stall <= (idle_mode != 0) && stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // result monitor
    entry_t want;

    always @(posedge clk)
    begin
        if (rst_n && entry_valid && !entry_stall)
        begin
            if (expected_entries.size() == 0)
                report_mismatch("unexpected word, column_index", column_index, 0);
            else
            begin
                want = expected_entries.pop_front();
                if (row_index !== want.row)
                    report_mismatch("row_index", row_index, want.row);
                if (column_index !== want.col)
                    report_mismatch("column_index", column_index, want.col);
                if (entry_value !== want.value)
                    report_mismatch("entry_value", entry_value, want.value);
                if (last_in_row !== want.last)
                    report_mismatch("last_in_row", last_in_row, want.last);
                if (row_end_pointer !== want.end_ptr)
                    report_mismatch("row_end_pointer", row_end_pointer, want.end_ptr);
                if (diag_saturated !== want.clipped)
                    report_mismatch("diag_saturated", diag_saturated, want.clipped);
                if (grid_done !== want.done)
                    report_mismatch("grid_done", grid_done, want.done);
            end
            entries_seen++;
        end
    end

    task automatic wait_until_idle();
        while (pending_cells.size() != 0 || item_valid || reg_writes.size() != 0 || cfg_valid
               || expected_entries.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [pscb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [pscb_pkg::EXT_W-1:0] data);
        reg_write_t w;
        w.index = idx;
        w.data  = data;
        reg_writes.insert(reg_writes.size(), w);
        wait_until_idle();
    endtask

    task automatic set_extents(input logic [pscb_pkg::EXT_W-1:0] ni,
                               input logic [pscb_pkg::EXT_W-1:0] nj,
                               input logic [pscb_pkg::EXT_W-1:0] nk);
        write_register(pscb_pkg::REG_EXTENT_I, ni);
        write_register(pscb_pkg::REG_EXTENT_J, nj);
        write_register(pscb_pkg::REG_EXTENT_K, nk);
    endtask

    task automatic offer_cell(input logic [pscb_pkg::VAL_W-1:0] a,
                              input logic [pscb_pkg::VAL_W-1:0] e,
                              input logic [pscb_pkg::VAL_W-1:0] w,
                              input logic [pscb_pkg::VAL_W-1:0] n,
                              input logic [pscb_pkg::VAL_W-1:0] s,
                              input logic [pscb_pkg::VAL_W-1:0] t,
                              input logic [pscb_pkg::VAL_W-1:0] b);
        cell_t c;
        c.alpha  = a;
        c.east   = e;
        c.west   = w;
        c.north  = n;
        c.south  = s;
        c.top    = t;
        c.bottom = b;
        pending_cells.insert(pending_cells.size(), c);
    endtask

    // extremes often enough that the diagonal clips now and then
    function automatic logic [pscb_pkg::VAL_W-1:0] random_coef();
        case ($urandom_range(0, 9))
            0: return POS_FULL;
            1: return NEG_FULL;
            2: return '0;
            3: return pscb_pkg::VAL_W'(int'($urandom_range(0, 131071)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    task automatic offer_random_cells(input int count);
        repeat (count)
            offer_cell(random_coef(), random_coef(), random_coef(), random_coef(),
                       random_coef(), random_coef(), random_coef());
    endtask

    function automatic logic [pscb_pkg::EXT_W-1:0] pick_extent();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return pscb_pkg::EXT_W'(GRID_MAX);
            2: return '1;
            3: return pscb_pkg::EXT_W'($urandom_range(0, 511));
            default: return pscb_pkg::EXT_W'($urandom_range(1, 5));
        endcase
    endfunction

    int                         random_done = 0;
    int                         phase       = 0;
    int                         cells;
    longint                     grid_cells;
    logic [pscb_pkg::EXT_W-1:0] ni, nj, nk;

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset extents, full-scale and clipping diagonals
        offer_cell('0, '0, '0, '0, '0, '0, '0);
        offer_cell(POS_FULL, '0, '0, '0, '0, '0, '0);
        offer_cell(NEG_FULL, '0, '0, '0, '0, '0, '0);
        offer_cell(POS_FULL, NEG_FULL, NEG_FULL, NEG_FULL, NEG_FULL, NEG_FULL, NEG_FULL);
        offer_cell(NEG_FULL, POS_FULL, POS_FULL, POS_FULL, POS_FULL, POS_FULL, POS_FULL);
        offer_cell(NEG_FULL, 32'sd1, '0, '0, '0, '0, '0);
        offer_cell(POS_FULL, -32'sd1, '0, '0, '0, '0, '0);
        offer_cell(32'h0001_0000, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6);
        wait_until_idle();

        // every neighbour on the same column, every cell ends the grid
        set_extents(9'd1, 9'd1, 9'd1);
        offer_random_cells(2);
        wait_until_idle();

        set_extents(9'd2, 9'd1, 9'd3);
        offer_random_cells(6);
        wait_until_idle();

        // a write to the unused index must not restart the walk
        set_extents(9'd3, 9'd3, 9'd3);
        offer_random_cells(2);
        wait_until_idle();
        write_register(REG_UNUSED, '1);
        offer_random_cells(2);
        wait_until_idle();

        set_extents('0, '0, '0);
        offer_random_cells(1);
        wait_until_idle();

        // longest fastest axis, run to the end so the east wrap is seen
        idle_mode = 1;
        set_extents('1, 9'd1, 9'd1);
        offer_random_cells(256);
        random_done += 256;
        wait_until_idle();

        idle_mode = 0;
        set_extents(9'd2, 9'd3, 9'd256);
        offer_random_cells(30);
        random_done += 30;
        wait_until_idle();

        // run at least until the hold-off and the drain phases have been through
        while (random_done < RANDOM_CELLS || phase < 5)
        begin
            ni = pick_extent();
            nj = pick_extent();
            nk = pick_extent();
            set_extents(ni, nj, nk);
            grid_cells = effective_extent(ni) * effective_extent(nj) * effective_extent(nk);
            if (grid_cells <= 40)
                cells = int'(grid_cells) * $urandom_range(1, 3) + $urandom_range(0, 2);
            else
                cells = $urandom_range(20, 40);
            idle_mode = $urandom_range(0, 2);
            if (phase == 2)
            begin
                // receiver holds off while the sender keeps offering
                idle_mode = 0;
                hold_requests++;
                cells = 40;
            end
            offer_random_cells(cells);
            random_done += cells;
            if (phase == 4)
            begin
                // sender stops until the block has drained completely
                while (pending_cells.size() > cells / 2)
                    @(negedge clk);
                hold_items = 1'b1;
                while (item_valid || expected_entries.size() != 0)
                    @(negedge clk);
                hold_items = 1'b0;
            end
            wait_until_idle();
            phase++;
        end

        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("periodic_stencil_csr_row_builder_test passed");
        else
            $display("periodic_stencil_csr_row_builder_test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("periodic_stencil_csr_row_builder_test failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pscb_pkg.sv
rtl/pscb_ctrl.sv
rtl/pscb_dpath.sv
rtl/periodic_stencil_csr_row_builder.sv
bench/periodic_stencil_csr_row_builder_test.sv
